/* rtl/lc3_pkg.sv */
// Shared types, opcode codes and helper functions for the LC-3 execute core.
// Used by lc3_instruction_execute_core and its checker; no dependencies.
package lc3_pkg;

    localparam int ADDR_WIDTH_DEF = 16;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 72;

    // Command codes on the input beat
    localparam logic [1:0] CMD_EXEC   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_SET_PC = 2'd2;

    // Opcodes
    localparam logic [3:0] OPC_BR   = 4'h0;
    localparam logic [3:0] OPC_ADD  = 4'h1;
    localparam logic [3:0] OPC_LD   = 4'h2;
    localparam logic [3:0] OPC_ST   = 4'h3;
    localparam logic [3:0] OPC_JSR  = 4'h4;
    localparam logic [3:0] OPC_AND  = 4'h5;
    localparam logic [3:0] OPC_LDR  = 4'h6;
    localparam logic [3:0] OPC_STR  = 4'h7;
    localparam logic [3:0] OPC_NOT  = 4'h9;
    localparam logic [3:0] OPC_LDI  = 4'hA;
    localparam logic [3:0] OPC_STI  = 4'hB;
    localparam logic [3:0] OPC_JMP  = 4'hC;
    localparam logic [3:0] OPC_LEA  = 4'hE;
    localparam logic [3:0] OPC_TRAP = 4'hF;

    // Trap vectors
    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_IN   = 8'h23;
    localparam logic [7:0] TRAP_HALT = 8'h25;

    // Condition codes
    localparam logic [1:0] CC_UNSET = 2'd0;
    localparam logic [1:0] CC_N     = 2'd1;
    localparam logic [1:0] CC_Z     = 2'd2;
    localparam logic [1:0] CC_P     = 2'd3;

    localparam logic [2:0] REG_R0 = 3'd0;
    localparam logic [2:0] REG_R7 = 3'd7;

    // Result beat, pc in the lowest bits
    typedef struct packed {
        logic [15:0] reg_value;
        logic [2:0]  reg_index;
        logic        reg_written;
        logic        call_pause;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        halted;
        logic [1:0]  cc;
        logic [15:0] instr;
        logic [15:0] pc;
    } result_t;

    function automatic logic [15:0] sext9(input logic [15:0] w);
        return {{7{w[8]}}, w[8:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] w);
        return {{10{w[5]}}, w[5:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] w);
        return {{11{w[4]}}, w[4:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] w);
        return {{5{w[10]}}, w[10:0]};
    endfunction

    function automatic logic [1:0] cc_of(input logic [15:0] v);
        logic [1:0] c;
        if (v == 16'd0) begin
            c = CC_Z;
        end else if (v[15]) begin
            c = CC_N;
        end else begin
            c = CC_P;
        end
        return c;
    endfunction

endpackage

/* rtl/lc3_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/lc3_instruction_execute_core.sv */
// LC-3 execute core top level: sequencer, main memory and register file.
// Depends on lc3_pkg and lc3_ram.
//
// Each input beat is one command. Memory writes, PC loads and commands that
// do nothing give their result beat in the cycle after acceptance. An executed
// instruction goes through fetch, register read and execute; LD, LDR and STI
// add one more access to the single-port main memory and LDI adds two, each in
// its own state, since the registered read sets the pace. The next beat is taken
// as soon as the sequencer is back in idle and the previous result beat is
// either gone or leaving in the same cycle.
module lc3_instruction_execute_core #(
    parameter int ADDR_WIDTH = lc3_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: op[1:0], addr[17:2], data[33:18], key_char[41:34], zero pad
    input  logic [lc3_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: pc, instr, cc, halted, char_valid, char_out, call_pause,
    //          reg_written, reg_index, reg_value, zero pad
    output logic [lc3_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import lc3_pkg::*;

    localparam int DEPTH = 1 << ADDR_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_MEM1, ST_MEM2
    } state_t;

    state_t      state_reg;
    logic [15:0] pc_reg;
    logic [15:0] ir_reg;
    logic [1:0]  cc_reg;
    logic        halt_reg;
    logic [7:0]  key_reg;
    logic [15:0] sval_reg;
    logic [7:0]  rvalid_reg;
    logic        va_reg, vb_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    // Input fields
    logic [1:0]  in_op;
    logic [15:0] in_addr, in_data;
    logic [7:0]  in_key;
    assign in_op   = s_tdata[1:0];
    assign in_addr = s_tdata[17:2];
    assign in_data = s_tdata[33:18];
    assign in_key  = s_tdata[41:34];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Main memory port
    logic                  mem_we;
    logic [15:0]           mem_addr16;
    logic [15:0]           mem_wdata, mem_rdata;
    logic [ADDR_WIDTH-1:0] mem_addr;
    assign mem_addr = mem_addr16[ADDR_WIDTH-1:0];

    lc3_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_main_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Register file: two mirrored copies for two reads a cycle
    logic        rf_we;
    logic [2:0]  rf_waddr, rf_ra, rf_rb;
    logic [15:0] rf_wdata, rf_da, rf_db;

    lc3_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra), .rdata(rf_da)
    );
    lc3_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_rb), .rdata(rf_db)
    );

    // Never-written registers read as zero
    logic [15:0] src1, src2;
    assign src1 = va_reg ? rf_da : 16'd0;
    assign src2 = vb_reg ? rf_db : 16'd0;

    // Read addresses come from the fetched word
    logic [3:0] f_opc;
    assign f_opc = mem_rdata[15:12];
    assign rf_ra = mem_rdata[8:6];
    always_comb begin
        priority if (f_opc == OPC_ADD || f_opc == OPC_AND) begin
            rf_rb = mem_rdata[2:0];
        end else if (f_opc == OPC_ST || f_opc == OPC_STR || f_opc == OPC_STI) begin
            rf_rb = mem_rdata[11:9];
        end else begin
            rf_rb = REG_R0;
        end
    end

    // Decode helpers
    logic [3:0]  opc;
    logic [2:0]  dr;
    logic [15:0] pc_off9, base_off6, opb;
    logic        br_taken;
    assign opc       = ir_reg[15:12];
    assign dr        = ir_reg[11:9];
    assign pc_off9   = pc_reg + sext9(ir_reg);
    assign base_off6 = src1 + sext6(ir_reg);
    assign opb       = ir_reg[5] ? sext5(ir_reg) : src2;
    assign br_taken  = (ir_reg[11] && cc_reg == CC_N) || (ir_reg[10] && cc_reg == CC_Z)
                    || (ir_reg[9] && cc_reg == CC_P);

    // Finish logic and memory control per state
    logic        fin, wr, setcc, pause, cvalid, halt_set;
    logic [15:0] rval, newpc;
    logic [7:0]  cout;
    state_t      state_next;

    always_comb begin
        fin        = 1'b0;
        wr         = 1'b0;
        setcc      = 1'b0;
        pause      = 1'b0;
        cvalid     = 1'b0;
        halt_set   = 1'b0;
        rval       = 16'd0;
        newpc      = pc_reg;
        cout       = 8'd0;
        mem_we     = 1'b0;
        mem_addr16 = pc_reg;
        mem_wdata  = src2;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_op == CMD_WRITE) begin
                    mem_we     = 1'b1;
                    mem_addr16 = in_addr;
                    mem_wdata  = in_data;
                end else if (accept && in_op == CMD_EXEC && !halt_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                fin = 1'b1;
                unique case (opc)
                    OPC_BR: begin
                        if (br_taken) begin
                            newpc = pc_off9;
                        end
                    end
                    OPC_ADD, OPC_AND: begin
                        rval  = (opc == OPC_ADD) ? src1 + opb : src1 & opb;
                        wr    = 1'b1;
                        setcc = 1'b1;
                    end
                    OPC_LD, OPC_LDI: begin
                        fin        = 1'b0;
                        mem_addr16 = pc_off9;
                        state_next = ST_MEM1;
                    end
                    OPC_LDR: begin
                        fin        = 1'b0;
                        mem_addr16 = base_off6;
                        state_next = ST_MEM1;
                    end
                    OPC_ST: begin
                        mem_we     = 1'b1;
                        mem_addr16 = pc_off9;
                    end
                    OPC_STR: begin
                        mem_we     = 1'b1;
                        mem_addr16 = base_off6;
                    end
                    OPC_STI: begin
                        fin        = 1'b0;
                        mem_addr16 = pc_off9;
                        state_next = ST_MEM1;
                    end
                    OPC_JSR: begin
                        newpc = ir_reg[11] ? src1 : pc_reg + sext11(ir_reg);
                        rval  = pc_reg;
                        wr    = 1'b1;
                        pause = 1'b1;
                    end
                    OPC_NOT: begin
                        rval  = ~src1;
                        wr    = 1'b1;
                        setcc = 1'b1;
                    end
                    OPC_JMP: begin
                        newpc = src1;
                    end
                    OPC_LEA: begin
                        rval  = pc_off9;
                        wr    = 1'b1;
                        setcc = 1'b1;
                    end
                    OPC_TRAP: begin
                        priority if (ir_reg[7:0] == TRAP_GETC || ir_reg[7:0] == TRAP_IN) begin
                            rval = {8'd0, key_reg};
                            wr   = 1'b1;
                        end else if (ir_reg[7:0] == TRAP_OUT) begin
                            cvalid = 1'b1;
                            cout   = src2[7:0];
                        end else if (ir_reg[7:0] == TRAP_HALT) begin
                            halt_set = 1'b1;
                        end else begin
                            halt_set = 1'b0;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (fin) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEM1: begin
                mem_addr16 = mem_rdata;
                mem_wdata  = sval_reg;
                priority if (opc == OPC_LDI) begin
                    state_next = ST_MEM2;
                end else if (opc == OPC_STI) begin
                    mem_we     = 1'b1;
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rval       = mem_rdata;
                    wr         = 1'b1;
                    setcc      = 1'b1;
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MEM2: begin
                rval       = mem_rdata;
                wr         = 1'b1;
                setcc      = 1'b1;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register write: traps and JSR target fixed registers
    always_comb begin
        if (opc == OPC_JSR) begin
            rf_waddr = REG_R7;
        end else if (opc == OPC_TRAP) begin
            rf_waddr = REG_R0;
        end else begin
            rf_waddr = dr;
        end
    end
    assign rf_we    = fin && wr;
    assign rf_wdata = rval;

    // Sequencer state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 16'd0;
            ir_reg        <= 16'd0;
            cc_reg        <= CC_UNSET;
            halt_reg      <= 1'b0;
            rvalid_reg    <= 8'd0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Load a new result beat, else drop the one taken
            if (fin || (accept && (in_op != CMD_EXEC || halt_reg))) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg <= in_key;
                        if (in_op != CMD_EXEC || halt_reg) begin
                            out_reg.pc          <= (in_op == CMD_SET_PC) ? in_addr : pc_reg;
                            out_reg.instr       <= ir_reg;
                            out_reg.cc          <= cc_reg;
                            out_reg.halted      <= (in_op == CMD_SET_PC) ? 1'b0 : halt_reg;
                            out_reg.char_valid  <= 1'b0;
                            out_reg.char_out    <= 8'd0;
                            out_reg.call_pause  <= 1'b0;
                            out_reg.reg_written <= 1'b0;
                            out_reg.reg_index   <= REG_R0;
                            out_reg.reg_value   <= 16'd0;
                            if (in_op == CMD_SET_PC) begin
                                pc_reg   <= in_addr;
                                halt_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_FETCH: begin
                    ir_reg <= mem_rdata;
                    pc_reg <= pc_reg + 16'd1;
                    va_reg <= rvalid_reg[rf_ra];
                    vb_reg <= rvalid_reg[rf_rb];
                end
                ST_EXEC: begin
                    sval_reg <= src2;
                end
                ST_MEM1, ST_MEM2: begin
                    sval_reg <= sval_reg;
                end
                default: begin
                    sval_reg <= sval_reg;
                end
            endcase
            // Commit an executed instruction
            if (fin) begin
                pc_reg <= newpc;
                if (halt_set) begin
                    halt_reg <= 1'b1;
                end
                if (wr) begin
                    rvalid_reg[rf_waddr] <= 1'b1;
                    if (setcc) begin
                        cc_reg <= cc_of(rval);
                    end
                end
                out_reg.pc          <= newpc;
                out_reg.instr       <= ir_reg;
                out_reg.cc          <= (wr && setcc) ? cc_of(rval) : cc_reg;
                out_reg.halted      <= halt_reg | halt_set;
                out_reg.char_valid  <= cvalid;
                out_reg.char_out    <= cout;
                out_reg.call_pause  <= pause;
                out_reg.reg_written <= wr;
                out_reg.reg_index   <= wr ? rf_waddr : REG_R0;
                out_reg.reg_value   <= wr ? rval : 16'd0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_reg};

endmodule

/* rtl/lc3_checker.sv */
// Port-level checker for the LC-3 execute core, bound to the top level.
// Depends on lc3_pkg and lc3_instruction_execute_core.
module lc3_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [lc3_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lc3_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import lc3_pkg::*;

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Set-PC answers next cycle with the new PC and halt cleared
    a_set_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == CMD_SET_PC
        |=> m_tvalid && m_tdata[15:0] == $past(s_tdata[17:2]) && !m_tdata[34])
        else $error("set-PC result wrong");

    // Register fields stay zero when nothing was written
    a_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[45] |-> m_tdata[48:46] == 3'd0 && m_tdata[64:49] == 16'd0)
        else $error("register fields set without a write");

endmodule

bind lc3_instruction_execute_core lc3_checker u_lc3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* dv/lc3_instruction_execute_core_tb.sv */
// Self-checking testbench for the LC-3 execute core: predicts each result beat
// from its own copy of memory, registers, PC and flags. Needs lc3_pkg and the RTL.
module lc3_instruction_execute_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lc3_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    // Shadow of the core: expects one result beat per accepted command beat
    class lc3_scoreboard;
        logic [15:0] mem [int];
        logic [15:0] regs [8];
        logic [15:0] pc_q;
        logic [15:0] ir_q;
        logic [1:0]  cc_q;
        logic        halt_q;
        result_t     pending_q [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc_q = '0; ir_q = '0; cc_q = CC_UNSET; halt_q = 1'b0; errors = 0;
        endfunction

        function logic [15:0] rd(logic [15:0] a);
            return mem.exists(a) ? mem[a] : 16'd0;
        endfunction

        function logic [15:0] sx(logic [15:0] w, int bits);
            logic [15:0] v;
            v = w;
            for (int i = bits; i < 16; i++) v[i] = w[bits-1];
            return v;
        endfunction

        function logic [1:0] code_of(logic [15:0] v);
            if (v == 16'd0) return CC_Z;
            return v[15] ? CC_N : CC_P;
        endfunction

        function void note_input(logic [1:0] op, logic [15:0] a, logic [15:0] d,
                                 logic [7:0] key);
            result_t     r;
            logic [15:0] ir, npc, sr1, b, val;
            logic [2:0]  dst;
            logic        wr, setcc;
            r = '0;
            wr = 0; setcc = 0; val = '0; dst = '0;
            if (op == CMD_WRITE) begin
                mem[a] = d;
            end else if (op == CMD_SET_PC) begin
                pc_q = a;
                halt_q = 1'b0;
            end else if (op == CMD_EXEC && !halt_q) begin
                ir = rd(pc_q);
                npc = pc_q + 16'd1;
                dst = ir[11:9];
                sr1 = regs[ir[8:6]];
                ir_q = ir;
                case (ir[15:12])
                    OPC_BR: begin
                        if ((ir[11] && cc_q == CC_N) || (ir[10] && cc_q == CC_Z) ||
                            (ir[9] && cc_q == CC_P))
                            npc = npc + sx(ir, 9);
                    end
                    OPC_ADD, OPC_AND: begin
                        b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
                        val = (ir[15:12] == OPC_ADD) ? sr1 + b : sr1 & b;
                        wr = 1; setcc = 1;
                    end
                    OPC_LD: begin
                        val = rd(npc + sx(ir, 9)); wr = 1; setcc = 1;
                    end
                    OPC_ST: mem[npc + sx(ir, 9)] = regs[dst];
                    OPC_JSR: begin
                        b = ir[11] ? sr1 : npc + sx(ir, 11);
                        val = npc; wr = 1; dst = REG_R7;
                        npc = b;
                        r.call_pause = 1'b1;
                    end
                    OPC_LDR: begin
                        val = rd(sr1 + sx(ir, 6)); wr = 1; setcc = 1;
                    end
                    OPC_STR: mem[sr1 + sx(ir, 6)] = regs[dst];
                    OPC_NOT: begin
                        val = ~sr1; wr = 1; setcc = 1;
                    end
                    OPC_LDI: begin
                        val = rd(rd(npc + sx(ir, 9))); wr = 1; setcc = 1;
                    end
                    OPC_STI: mem[rd(npc + sx(ir, 9))] = regs[dst];
                    OPC_JMP: npc = sr1;
                    OPC_LEA: begin
                        val = npc + sx(ir, 9); wr = 1; setcc = 1;
                    end
                    OPC_TRAP: begin
                        case (ir[7:0])
                            TRAP_GETC, TRAP_IN: begin
                                val = {8'd0, key}; wr = 1; dst = REG_R0;
                            end
                            TRAP_OUT: begin
                                r.char_valid = 1'b1;
                                r.char_out = regs[0][7:0];
                            end
                            TRAP_HALT: halt_q = 1'b1;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                if (wr) begin
                    regs[dst] = val;
                    if (setcc) cc_q = code_of(val);
                end
                pc_q = npc;
            end
            r.pc = pc_q;
            r.instr = ir_q;
            r.cc = cc_q;
            r.halted = halt_q;
            r.reg_written = wr;
            r.reg_index = wr ? dst : 3'd0;
            r.reg_value = wr ? val : 16'd0;
            pending_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            e = pending_q.pop_front();
            if (got.pc !== e.pc || got.instr !== e.instr || got.cc !== e.cc ||
                got.halted !== e.halted || got.char_valid !== e.char_valid ||
                got.char_out !== e.char_out || got.call_pause !== e.call_pause ||
                got.reg_written !== e.reg_written || got.reg_index !== e.reg_index ||
                got.reg_value !== e.reg_value) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: pc=%h ir=%h cc=%0d h=%b cv=%b co=%h cp=%b w=%b r%0d=%h",
                             e.pc, e.instr, e.cc, e.halted, e.char_valid, e.char_out,
                             e.call_pause, e.reg_written, e.reg_index, e.reg_value);
                    $display("         got: pc=%h ir=%h cc=%0d h=%b cv=%b co=%h cp=%b w=%b r%0d=%h",
                             got.pc, got.instr, got.cc, got.halted, got.char_valid,
                             got.char_out, got.call_pause, got.reg_written,
                             got.reg_index, got.reg_value);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    lc3_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    lc3_instruction_execute_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random backpressure on the result side
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[64:0]));
    end

    // Present one command beat from a falling edge and hold it until taken
    task automatic send(logic [1:0] op, logic [15:0] a, logic [15:0] d, logic [7:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, key, d, a, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, a, d, key);
        @(negedge aclk);
    endtask

    task automatic fill_if_blank(logic [15:0] a);
        if (!sb.mem.exists(a)) send(CMD_WRITE, a, 16'($urandom), 8'($urandom));
    endtask

    // Place a word at the PC (or keep the one there), back its loads, execute
    task automatic run_instr(logic [15:0] w, bit keep);
        logic [15:0] npc, ea;
        if (!sb.halt_q) begin
            if (!(keep && sb.mem.exists(sb.pc_q))) send(CMD_WRITE, sb.pc_q, w, 8'($urandom));
            w = sb.rd(sb.pc_q);
            npc = sb.pc_q + 16'd1;
            ea = npc + sb.sx(w, 9);
            case (w[15:12])
                OPC_LD, OPC_STI: fill_if_blank(ea);
                OPC_LDI: begin
                    fill_if_blank(ea);
                    fill_if_blank(sb.rd(ea));
                end
                OPC_LDR: fill_if_blank(sb.regs[w[8:6]] + sb.sx(w, 6));
                default: ;
            endcase
        end
        send(CMD_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [15:0] rand_instr();
        logic [15:0] w;
        logic [7:0]  vec [5] = '{TRAP_GETC, TRAP_OUT, TRAP_IN, TRAP_HALT, 8'h22};
        w = 16'($urandom);
        if (w[15:12] == OPC_TRAP && $urandom_range(9) < 8) begin
            w[11:8] = 4'd0;
            w[7:0] = (vec[$urandom_range(4)] == TRAP_HALT && $urandom_range(3) != 0)
                     ? TRAP_OUT : vec[$urandom_range(4)];
        end
        return w;
    endfunction

    initial begin
        logic [15:0] directed [] = '{
            16'h0E05, 16'h1021, 16'h127F, 16'h5440, 16'h5620, 16'h16FF, 16'h9A40,
            16'hE3FF, 16'h2401, 16'h6642, 16'hA5FE, 16'h3600, 16'h7E7F, 16'hB8FE,
            16'h0E01, 16'h0000, 16'hF020, 16'hF021, 16'hF023, 16'hF022, 16'h4802,
            16'h4DC0, 16'hC1C0, 16'h8000, 16'hD000};
        int r;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: unknown command, field extremes, each opcode, halt and resume
        send(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
        send(CMD_WRITE, 16'hFFFF, 16'hFFFF, 8'h00);
        send(CMD_SET_PC, 16'h3000, 16'h0000, 8'h00);
        foreach (directed[i]) run_instr(directed[i], 0);
        run_instr(16'hF025, 0);
        run_instr(16'h1021, 0);
        send(CMD_SET_PC, 16'hFFFF, 16'h0, 8'h0);
        run_instr(16'h0FFF, 0);

        // Random phases with different pacing
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 10 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 10 : 0;
            for (int n = 0; n < 190; n++) begin
                r = $urandom_range(99);
                if (sb.halt_q && r < 80)
                    send(CMD_SET_PC, 16'($urandom), 16'($urandom), 8'($urandom));
                else if (r < 5)
                    send(CMD_SET_PC, 16'($urandom), 16'($urandom), 8'($urandom));
                else if (r < 8)
                    send(CMD_NONE, 16'($urandom), 16'($urandom), 8'($urandom));
                else if (r < 13)
                    send(CMD_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
                else
                    run_instr(rand_instr(), $urandom_range(9) < 3);
            end
        end
        s_tvalid <= 1'b0;

        // Drain and allow trailing beats
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
